// ----- hw/rtl/modular_arithmetic_unit_assert.svh -----
// assertion macros for the modular arithmetic unit
`ifndef MODULAR_ARITHMETIC_UNIT_ASSERT_SVH
`define MODULAR_ARITHMETIC_UNIT_ASSERT_SVH
`ifndef SYNTH
`define MAU_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define MAU_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define MAU_ASSERT_IMPL(label, clk, rst, ante, cons)
`define MAU_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ----- hw/rtl/mau_pkg.sv -----
// ----------------------------------------------------------------------------
// mau_pkg
// shared widths and action codes of the modular arithmetic unit
// ----------------------------------------------------------------------------
package mau_pkg;
   localparam int unsigned ResW  = 31;
   localparam int unsigned WideW = 64;

   typedef enum logic [2:0] {
      ACT_ADD = 3'd0, ACT_SUB = 3'd1, ACT_MUL = 3'd2, ACT_DIV = 3'd3,
      ACT_NEG = 3'd4, ACT_INV = 3'd5, ACT_RED = 3'd6, ACT_NOP = 3'd7
   } action_type;

   typedef logic [ResW-1:0] res_type;
endpackage

// ----- hw/rtl/mau_mulmod.sv -----
// ----------------------------------------------------------------------------
// mau_mulmod
// bit-serial modular multiply: a * b mod m, one multiplier bit per cycle
// ----------------------------------------------------------------------------
module mau_mulmod (
   input  logic            clock,
   input  logic            reset,
   input  logic            go,
   input  mau_pkg::res_type a,
   input  mau_pkg::res_type b,
   input  mau_pkg::res_type m,
   output logic            done,
   output mau_pkg::res_type p
);
   import mau_pkg::*;

   logic            run_ff, run_in;
   logic [4:0]      cnt_ff, cnt_in;
   res_type         acc_ff, acc_in;
   res_type         mb_ff, mb_in;
   res_type         ma_ff, ma_in;
   logic            done_ff, done_in;
   logic [ResW:0]   dbl;
   logic [ResW:0]   add;
   res_type         d;

   // horner step from the top multiplier bit: acc = 2*acc (+ a) mod m
   always_comb begin
      dbl = {acc_ff, 1'b0};
      if (dbl >= {1'b0, ma_ff}) dbl = dbl - {1'b0, ma_ff};
      d = dbl[ResW-1:0];
      add = {1'b0, d} + {1'b0, a};
      if (mb_ff[ResW-1]) begin
         if (add >= {1'b0, ma_ff}) add = add - {1'b0, ma_ff};
      end else begin
         add = {1'b0, d};
      end
   end

   always_comb begin
      run_in = run_ff; cnt_in = cnt_ff; acc_in = acc_ff; mb_in = mb_ff;
      ma_in = ma_ff; done_in = 1'b0;
      if (go) begin
         run_in = 1'b1; cnt_in = 5'(ResW - 1); acc_in = '0; mb_in = b; ma_in = m;
      end else if (run_ff) begin
         acc_in = add[ResW-1:0];
         mb_in = {mb_ff[ResW-2:0], 1'b0};
         cnt_in = cnt_ff - 5'd1;
         if (cnt_ff == 5'd0) begin
            run_in = 1'b0; done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0; done_ff <= 1'b0;
      end else begin
         run_ff <= run_in; done_ff <= done_in;
      end
      cnt_ff <= cnt_in; acc_ff <= acc_in; mb_ff <= mb_in; ma_ff <= ma_in;
   end

   assign done = done_ff;
   assign p    = acc_ff;
endmodule

// ----- hw/rtl/modular_arithmetic_unit.sv -----
// ----------------------------------------------------------------------------
// modular_arithmetic_unit
// add, subtract, multiply, divide, negate, inverse and reduce over a modulus
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. Its single response
// appears for one cycle with done high and cannot be held off. Add, subtract
// and negate first reduce both operands (31 steps each, one bit a cycle),
// reduce runs 64 steps over the magnitude, multiply adds a further 31-step
// shift-and-add multiply, and a modulus below two or the unused action goes
// straight to the output state. Inverse runs extended euclid with every
// quotient found by shift and subtract; divide adds one multiply. busy stays
// high through the done cycle, so the next request is taken after it.
module modular_arithmetic_unit (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  logic [2:0]           req_action,
   input  logic [30:0]          req_operand_a,
   input  logic [30:0]          req_operand_b,
   input  logic signed [63:0]   req_wide_value,
   output logic                 done,
   output logic [30:0]          rsp_result,
   output logic                 rsp_equal,
   output logic                 rsp_no_inverse,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [30:0]          csr_data
);
   import mau_pkg::*;
   `include "modular_arithmetic_unit_assert.svh"

   // signed width of the euclid coefficients, magnitude never above the modulus
   localparam int unsigned SgnW = ResW + 3;

   typedef enum logic [3:0] {
      S_IDLE, S_RED, S_OP, S_GCD, S_ALN, S_DIV, S_FIX, S_MULW, S_OUT
   } state_type;

   state_type       st_ff;
   res_type         mod_ff;
   action_type      act_ff;
   res_type         a_ff, b_ff;
   logic            eq_ff;
   // remainder engine: shifts a value in one bit a cycle
   logic [WideW-1:0] sh_ff;
   logic [ResW:0]   rem_ff;
   logic [6:0]      cnt_ff;
   logic [1:0]      phase_ff;   // 0 reduce a, 1 reduce b, 2 reduce wide
   logic            neg_ff;
   // extended euclid: remainders r0,r1, coefficients s0,s1, shifted divisor d,e
   res_type                r0_ff, r1_ff;
   logic [ResW:0]          d_ff;
   logic signed [SgnW-1:0] s0_ff, s1_ff, e_ff;
   logic [4:0]             k_ff;
   res_type         res_ff;
   logic            noinv_ff;
   logic            done_ff;
   logic            mgo_ff;
   res_type         ma_ff, mb_ff;
   logic            mdone;
   res_type         mp;

   mau_mulmod u_mul (
      .clock(clock), .reset(reset), .go(mgo_ff), .a(ma_ff), .b(mb_ff),
      .m(mod_ff), .done(mdone), .p(mp)
   );

   // remainder step helper
   logic [ResW+1:0] rs;
   always_comb begin
      rs = {rem_ff, sh_ff[WideW-1]};
      if (rs >= {2'b0, mod_ff}) rs = rs - {2'b0, mod_ff};
   end

   // one quotient bit of euclid and the final coefficient brought into 0..m-1
   logic                   take;
   res_type                r0_sub;
   logic signed [SgnW-1:0] s0_sub;
   logic signed [SgnW-1:0] mod_s;
   logic signed [SgnW-1:0] s_fix;
   res_type                inv_val;
   always_comb begin
      mod_s  = {3'b0, mod_ff};
      take   = ({1'b0, r0_ff} >= d_ff);
      r0_sub = take ? ResW'({1'b0, r0_ff} - d_ff) : r0_ff;
      s0_sub = take ? (s0_ff - e_ff) : s0_ff;
      s_fix  = s0_ff;
      if (s_fix[SgnW-1]) s_fix = s_fix + mod_s;
      else if (s_fix >= mod_s) s_fix = s_fix - mod_s;
      inv_val = s_fix[ResW-1:0];
   end

   function automatic res_type subm(input res_type x, input res_type y,
                                    input res_type m);
      logic [ResW:0] t;
      begin
         t = {1'b0, x} - {1'b0, y};
         if (t[ResW]) t = t + {1'b0, m};
         subm = t[ResW-1:0];
      end
   endfunction

   logic [ResW:0] sum;
   assign sum = {1'b0, a_ff} + {1'b0, b_ff};

   // control and datapath
   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_IDLE; mod_ff <= 31'h7FFFFFFF; done_ff <= 1'b0; mgo_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0; mgo_ff <= 1'b0;
         if (csr_valid && csr_ready) mod_ff <= csr_data;
         unique case (st_ff)
            S_IDLE: begin
               if (start && !busy) begin
                  act_ff <= action_type'(req_action);
                  a_ff <= req_operand_a; b_ff <= req_operand_b;
                  eq_ff <= (req_operand_a == req_operand_b);
                  noinv_ff <= 1'b0; res_ff <= '0;
                  rem_ff <= '0; cnt_ff <= 7'(ResW); phase_ff <= 2'd0;
                  sh_ff <= {req_operand_a, 33'b0};
                  neg_ff <= req_wide_value[WideW-1];
                  if (req_action == ACT_RED) begin
                     phase_ff <= 2'd2; cnt_ff <= 7'(WideW);
                     sh_ff <= req_wide_value[WideW-1] ? -req_wide_value : req_wide_value;
                  end
                  st_ff <= (mod_ff < 31'd2 || req_action == ACT_NOP) ? S_OUT : S_RED;
               end
            end
            S_RED: begin
               if (cnt_ff != 7'd0) begin
                  rem_ff <= rs[ResW:0]; sh_ff <= {sh_ff[WideW-2:0], 1'b0};
                  cnt_ff <= cnt_ff - 7'd1;
               end else if (phase_ff == 2'd0) begin
                  a_ff <= rem_ff[ResW-1:0]; phase_ff <= 2'd1;
                  rem_ff <= '0; cnt_ff <= 7'(ResW); sh_ff <= {b_ff, 33'b0};
               end else if (phase_ff == 2'd1) begin
                  b_ff <= rem_ff[ResW-1:0]; st_ff <= S_OP;
               end else begin
                  res_ff <= (neg_ff && rem_ff != '0) ? mod_ff - rem_ff[ResW-1:0]
                                                     : rem_ff[ResW-1:0];
                  st_ff <= S_OUT;
               end
            end
            S_OP: begin
               case (act_ff)
                  ACT_ADD: begin
                     res_ff <= (sum >= {1'b0, mod_ff}) ? ResW'(sum - {1'b0, mod_ff})
                                                       : sum[ResW-1:0];
                     st_ff <= S_OUT;
                  end
                  ACT_SUB: begin res_ff <= subm(a_ff, b_ff, mod_ff); st_ff <= S_OUT; end
                  ACT_NEG: begin res_ff <= subm('0, a_ff, mod_ff); st_ff <= S_OUT; end
                  ACT_MUL: begin ma_ff <= a_ff; mb_ff <= b_ff; mgo_ff <= 1'b1;
                     st_ff <= S_MULW; end
                  default: begin
                     // inverse of b for divide, of a for inverse: r0 = m, r1 = x
                     r0_ff <= mod_ff;
                     r1_ff <= (act_ff == ACT_DIV) ? b_ff : a_ff;
                     s0_ff <= '0; s1_ff <= SgnW'(1);
                     st_ff <= S_GCD;
                  end
               endcase
            end
            S_GCD: begin
               // next euclid step while the divisor is nonzero
               if (r1_ff == '0) begin
                  st_ff <= S_FIX;
               end else begin
                  d_ff <= {1'b0, r1_ff}; e_ff <= s1_ff; k_ff <= '0; st_ff <= S_ALN;
               end
            end
            S_ALN: begin
               // shift the divisor up to the top quotient bit
               if ({d_ff, 1'b0} <= {2'b0, r0_ff}) begin
                  d_ff <= {d_ff[ResW-1:0], 1'b0};
                  e_ff <= {e_ff[SgnW-2:0], 1'b0};
                  k_ff <= k_ff + 5'd1;
               end else st_ff <= S_DIV;
            end
            S_DIV: begin
               // one quotient bit a cycle, then rotate the pairs
               if (k_ff == 5'd0) begin
                  r0_ff <= r1_ff; r1_ff <= r0_sub;
                  s0_ff <= s1_ff; s1_ff <= s0_sub;
                  st_ff <= S_GCD;
               end else begin
                  r0_ff <= r0_sub; s0_ff <= s0_sub;
                  d_ff <= d_ff >> 1; e_ff <= e_ff >>> 1;
                  k_ff <= k_ff - 5'd1;
               end
            end
            S_FIX: begin
               if (r0_ff != 31'd1) begin
                  noinv_ff <= 1'b1; res_ff <= '0; st_ff <= S_OUT;
               end else if (act_ff == ACT_INV) begin
                  res_ff <= inv_val; st_ff <= S_OUT;
               end else begin
                  ma_ff <= inv_val; mb_ff <= a_ff; mgo_ff <= 1'b1; st_ff <= S_MULW;
               end
            end
            S_MULW: if (mdone) begin res_ff <= mp; st_ff <= S_OUT; end
            S_OUT: begin done_ff <= 1'b1; st_ff <= S_IDLE; end
            default: st_ff <= S_IDLE;
         endcase
      end
   end

   assign busy           = (st_ff != S_IDLE) || done_ff;
   assign csr_ready      = !busy;
   assign done           = done_ff;
   assign rsp_result     = res_ff;
   assign rsp_equal      = eq_ff;
   assign rsp_no_inverse = noinv_ff;

   `MAU_ASSERT_NEXT(a_one_beat, clock, reset, done, !done)
   `MAU_ASSERT_IMPL(a_busy_done, clock, reset, done, busy)
   `MAU_ASSERT_IMPL(a_noinv_zero, clock, reset, done && rsp_no_inverse, rsp_result == '0)
endmodule

// ----- tb/sv/mau_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mau_checker
// watches the request, response and csr channels of the modular arithmetic
// unit, computes the expected residue for every request and compares it with
// each response beat, field by field
// ----------------------------------------------------------------------------
module mau_checker (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic                busy,
   input  logic [2:0]          req_action,
   input  logic [30:0]         req_operand_a,
   input  logic [30:0]         req_operand_b,
   input  logic signed [63:0]  req_wide_value,
   input  logic                done,
   input  logic [30:0]         rsp_result,
   input  logic                rsp_equal,
   input  logic                rsp_no_inverse,
   input  logic                csr_valid,
   input  logic                csr_ready,
   input  logic [30:0]         csr_data,
   output int                  fail_count,
   output int                  pending,
   output int                  rsp_count
);
   import mau_pkg::*;

   typedef struct packed {
      res_type residue;
      logic    equal;
      logic    no_inverse;
   } mau_rsp_type;

   logic [30:0] cur_modulus;
   mau_rsp_type residue_queue[$];

   // extended euclid; returns 0 when a is not invertible
   function automatic logic modular_inverse(input longint a, input longint m,
                                            output longint inv);
      longint r0, r1, s0, s1, q, t;
      r0 = m; r1 = a; s0 = 0; s1 = 1;
      while (r1 != 0) begin
         q  = r0 / r1;
         t  = r0 - q * r1; r0 = r1; r1 = t;
         t  = s0 - q * s1; s0 = s1; s1 = t;
      end
      inv = 0;
      if (r0 != 1) return 1'b0;
      s0 = s0 % m;
      if (s0 < 0) s0 += m;
      inv = s0;
      return 1'b1;
   endfunction

   function automatic mau_rsp_type compute_residue(input logic [2:0] act,
         input logic [30:0] ra, input logic [30:0] rb, input logic [63:0] wide,
         input logic [30:0] modv);
      mau_rsp_type r;
      logic [63:0] m, a, b, inv, mag, rem;
      r = '0;
      r.equal = (ra == rb);
      m = 64'(modv);
      if (m >= 2) begin
         a = 64'(ra) % m;
         b = 64'(rb) % m;
         case (action_type'(act))
            ACT_ADD: r.residue = res_type'((a + b) % m);
            ACT_SUB: r.residue = res_type'((a + m - b) % m);
            ACT_MUL: r.residue = res_type'((a * b) % m);
            ACT_DIV: begin
               if (modular_inverse(b, m, inv)) r.residue = res_type'((a * inv) % m);
               else r.no_inverse = 1'b1;
            end
            ACT_NEG: r.residue = res_type'((m - a) % m);
            ACT_INV: begin
               if (modular_inverse(a, m, inv)) r.residue = res_type'(inv);
               else r.no_inverse = 1'b1;
            end
            ACT_RED: begin
               if (wide[63]) begin
                  mag = ~wide + 64'd1;
                  rem = mag % m;
                  r.residue = res_type'((rem == 0) ? 64'd0 : m - rem);
               end else begin
                  r.residue = res_type'(wide % m);
               end
            end
            default: r.residue = '0;
         endcase
      end
      return r;
   endfunction

   // watch all channels at each edge
   always @(posedge clock) begin
      mau_rsp_type exp_r;
      if (reset) begin
         cur_modulus <= 31'h7FFFFFFF;
         residue_queue.delete();
         fail_count <= 0;
         pending    <= 0;
         rsp_count  <= 0;
      end else begin
         if (csr_valid && csr_ready) cur_modulus <= csr_data;
         if (done) begin
            rsp_count <= rsp_count + 1;
            if (residue_queue.size() == 0) begin
               $error("response beat with nothing expected");
               fail_count <= fail_count + 1;
            end else begin
               exp_r = residue_queue.pop_front();
               if (exp_r.residue !== rsp_result) begin
                  $error("result: expected %0d actual %0d", exp_r.residue, rsp_result);
                  fail_count <= fail_count + 1;
               end
               if (exp_r.equal !== rsp_equal) begin
                  $error("equal: expected %0d actual %0d", exp_r.equal, rsp_equal);
                  fail_count <= fail_count + 1;
               end
               if (exp_r.no_inverse !== rsp_no_inverse) begin
                  $error("no_inverse: expected %0d actual %0d",
                         exp_r.no_inverse, rsp_no_inverse);
                  fail_count <= fail_count + 1;
               end
            end
         end
         if (start && !busy)
            residue_queue.push_back(compute_residue(req_action, req_operand_a,
                                    req_operand_b, req_wide_value, cur_modulus));
         pending <= residue_queue.size();
      end
   end
endmodule

// ----- tb/sv/tb_modular_arithmetic_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_modular_arithmetic_unit
// drives directed and random requests across several moduli; a separate
// checker predicts every response and counts mismatches
// ----------------------------------------------------------------------------
module tb_modular_arithmetic_unit;
   import mau_pkg::*;

   localparam int CycleLimit = 3000000;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   logic [2:0]         req_action = '0;
   logic [30:0]        req_operand_a = '0;
   logic [30:0]        req_operand_b = '0;
   logic signed [63:0] req_wide_value = '0;
   logic               done;
   logic [30:0]        rsp_result;
   logic               rsp_equal;
   logic               rsp_no_inverse;
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic [30:0]        csr_data = '0;
   int                 fail_count, pending, rsp_count;
   int                 cycle_count = 0;
   int                 idle_pct;
   logic [30:0]        modulus_now = 31'h7FFFFFFF;

   modular_arithmetic_unit u_top (.*);

   mau_checker u_checker (.*);

   // clock
   initial begin
      forever #2 clock = ~clock;
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CycleLimit) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   // random residue: mostly below modulus, sometimes raw extremes
   function automatic logic [30:0] pick_residue();
      int sel;
      sel = $urandom_range(0, 19);
      if (sel == 0) return '0;
      if (sel == 1) return 31'h7FFFFFFF;
      if (sel == 2) return modulus_now - 1;
      if (sel == 3) return 31'($urandom);
      if (sel == 4) return 31'd1;
      return 31'($urandom % modulus_now);
   endfunction

   // one request beat, waits until accepted and then drops start
   task automatic send_req(input logic [2:0] act, input logic [30:0] a,
                           input logic [30:0] b, input logic [63:0] w);
      while ($urandom_range(0, 99) < idle_pct) @(posedge clock);
      start          <= 1'b1;
      req_action     <= act;
      req_operand_a  <= a;
      req_operand_b  <= b;
      req_wide_value <= w;
      do @(posedge clock); while (busy);
      start <= 1'b0;
      @(posedge clock);
   endtask

   // csr write once every expected beat is back and the unit has settled
   task automatic write_modulus(input logic [30:0] m);
      while (pending != 0) @(posedge clock);
      repeat (2100) @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= m;
      do @(posedge clock); while (!csr_ready);
      csr_valid   <= 1'b0;
      modulus_now  = m;
   endtask

   task automatic random_reqs(input int n);
      logic [2:0] act;
      logic [30:0] a;
      for (int i = 0; i < n; i++) begin
         act = 3'($urandom_range(0, 7));
         a   = pick_residue();
         send_req(act, a, ($urandom_range(0, 7) == 0) ? a : pick_residue(),
                  {$urandom, $urandom});
      end
   endtask

   initial begin
      logic [30:0] moduli[6];
      moduli = '{31'd2, 31'd97, 31'd1000, 31'd65537, 31'd3, 31'h7FFFFFFF};
      idle_pct = 15;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: every action and the edge values at the reset modulus
      for (int act = 0; act < 8; act++) begin
         send_req(3'(act), 31'h7FFFFFFE, 31'h7FFFFFFE, 64'h8000_0000_0000_0000);
         send_req(3'(act), '0, 31'h7FFFFFFF, 64'h7FFF_FFFF_FFFF_FFFF);
      end
      send_req(ACT_RED, '0, '0, 64'hFFFF_FFFF_FFFF_FFFF);
      send_req(ACT_RED, '0, '0, 64'hFFFF_FFFF_8000_0001);
      send_req(ACT_INV, 31'h7FFFFFFF, '0, '0);
      write_modulus(31'd12);
      send_req(ACT_INV, 31'd4, '0, '0);
      send_req(ACT_DIV, 31'd5, 31'd6, '0);
      send_req(ACT_INV, 31'd7, '0, '0);
      send_req(ACT_ADD, 31'd30, 31'd29, '0);
      write_modulus(31'd0);
      send_req(ACT_INV, 31'd3, 31'd3, 64'd5);
      write_modulus(31'd1);
      send_req(ACT_RED, 31'd3, 31'd4, -64'sd5);

      // random phases across moduli and idle settings
      for (int ph = 0; ph < 6; ph++) begin
         idle_pct = (ph < 2) ? 15 : (ph < 4) ? 70 : 0;
         write_modulus((ph == 5) ? 31'($urandom_range(2, 32'h7FFFFFFF)) : moduli[ph]);
         random_reqs(200);
      end
      write_modulus(31'h7FFFFFFF);
      random_reqs(230);

      while (pending != 0) @(posedge clock);
      repeat (2100) @(posedge clock);
      $display("covered %0d responses over ten modulus values, odd and even,",
               rsp_count);
      $display("including 0, 1, 2 and the largest, with every action code");
      if (fail_count == 0) $display("== PASS ==");
      else $display("== FAIL ==");
      $finish;
   end
endmodule
